[rtl/tof_pkg.sv]
// Shared types and constants for the timed opacity fade engine.
`timescale 1ns / 1ps
`default_nettype none

package tof_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned KIND_W  = 2;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MASTER = 2'd2;

  localparam logic [LEVEL_W-1:0] MASTER_RESET = 8'd255;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now;
    logic [LEVEL_W-1:0] target_level;
    logic [LEN_W-1:0]   fade_length;
    logic [LEVEL_W-1:0] master_level;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COMP_W-1:0]  composite;
    logic               fading;
  } res_t;

endpackage

`default_nettype wire

[rtl/timed_opacity_fade.sv]
// Linear opacity fade engine with a serial divider for tick interpolation.
// Path: set-target, master and idle ticks go from accept straight to S_FIN; a tick
//   that ends a fade passes S_CMP first, an interpolating one S_CMP, S_MUL, S_DIV (40 divide steps), S_APPLY.
// Throughput: one command at a time; cmd_stall is high until the result is loaded.
//   The 40-step restoring divider sets the tick cost.
// Reset: rst (synchronous) gives level 0, master 255, no fade running, no result.
`timescale 1ns / 1ps
`default_nettype none

module timed_opacity_fade (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire tof_pkg::cmd_t   cmd,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output tof_pkg::res_t        res
);

  import tof_pkg::*;

  localparam int unsigned PROD_W = TIME_W + LEVEL_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMP   = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_APPLY = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t              state;

  // Architectural fade state
  logic [LEVEL_W-1:0]  current_level;
  logic [LEVEL_W-1:0]  master;
  logic [LEVEL_W-1:0]  fade_from;
  logic [LEVEL_W-1:0]  fade_to;
  logic [LEN_W-1:0]    fade_time;
  logic [TIME_W-1:0]   fade_begin;

  // Datapath registers for the tick interpolation
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   elapsed_mag;
  logic [LEVEL_W-1:0]  delta_mag;
  logic                step_neg;
  logic [PROD_W-1:0]   dvd;
  logic [LEN_W-1:0]    rem;
  logic [LEVEL_W-1:0]  quot;
  logic [CNT_W-1:0]    count;

  logic                cmd_take;
  logic                res_free;
  logic [LEVEL_W:0]    delta;
  logic [LEN_W+1:0]    trial;
  logic [LEVEL_W-1:0]  step;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && (state == S_IDLE);
  assign res_free  = !res_valid || !res_stall;

  // Signed difference of the fade end points
  assign delta = {1'b0, fade_to} - {1'b0, fade_from};

  // One restoring divide step: shifted remainder minus the fade length
  assign trial = {1'b0, rem, dvd[PROD_W-1]} - {2'b00, fade_time};

  // Signed step, kept to its low byte
  assign step = step_neg ? (LEVEL_W'(0) - quot) : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      current_level <= '0;
      master        <= MASTER_RESET;
      fade_from     <= '0;
      fade_to       <= '0;
      fade_time     <= '0;
      fade_begin    <= '0;
    end else begin
      // Result beat leaves when the sink takes it; S_FIN reloads it itself
      if (res_valid && !res_stall && state != S_FIN) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            state   <= (cmd.kind == KIND_TICK && fade_time != '0) ? S_CMP : S_FIN;
            elapsed <= cmd.now - fade_begin;
            case (cmd.kind)
              KIND_TICK: begin
                // interpolation runs from S_CMP while a fade is active
              end
              KIND_TARGET: begin
                if (fade_time != '0 && fade_to == cmd.target_level &&
                    fade_time == cmd.fade_length) begin
                  // same fade already running: no change
                end else if (cmd.target_level == current_level) begin
                  fade_to   <= cmd.target_level;
                  fade_time <= '0;
                end else begin
                  fade_begin <= cmd.now;
                  fade_time  <= cmd.fade_length;
                  fade_from  <= current_level;
                  fade_to    <= cmd.target_level;
                  if (cmd.fade_length == '0) begin
                    current_level <= cmd.target_level;
                  end
                end
              end
              KIND_MASTER: begin
                master <= cmd.master_level;
              end
              default: begin
                // unused kind: state unchanged
              end
            endcase
          end
        end

        // Fade over, or set up magnitudes for the interpolation
        S_CMP: begin
          if (!elapsed[TIME_W-1] && (elapsed[LEN_W-1:0] >= fade_time)) begin
            current_level <= fade_to;
            fade_time     <= '0;
            state         <= S_FIN;
          end else begin
            elapsed_mag <= elapsed[TIME_W-1] ? (TIME_W'(0) - elapsed) : elapsed;
            delta_mag   <= delta[LEVEL_W] ? LEVEL_W'(~delta + 1'b1) : delta[LEVEL_W-1:0];
            step_neg    <= elapsed[TIME_W-1] ^ delta[LEVEL_W];
            state       <= S_MUL;
          end
        end

        // Exact product |elapsed| * |delta|
        S_MUL: begin
          dvd   <= PROD_W'(elapsed_mag) * PROD_W'(delta_mag);
          rem   <= '0;
          quot  <= '0;
          count <= CNT_W'(PROD_W - 1);
          state <= S_DIV;
        end

        // Restoring division, one quotient bit per cycle
        S_DIV: begin
          dvd  <= {dvd[PROD_W-2:0], 1'b0};
          quot <= {quot[LEVEL_W-2:0], ~trial[LEN_W+1]};
          if (!trial[LEN_W+1]) begin
            rem <= trial[LEN_W-1:0];
          end else begin
            rem <= {rem[LEN_W-2:0], dvd[PROD_W-1]};
          end
          count <= count - 1'b1;
          if (count == '0) begin
            state <= S_APPLY;
          end
        end

        S_APPLY: begin
          current_level <= fade_from + step;
          state         <= S_FIN;
        end

        // Load the result register once it is free
        S_FIN: begin
          if (res_free) begin
            res_valid     <= 1'b1;
            res.level     <= current_level;
            res.composite <= COMP_W'(master) * COMP_W'(current_level);
            res.fading    <= (fade_time != '0);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
